FILE: hw/rtl/scc_pkg.sv
`default_nettype none
package scc_pkg;

    // Number of colour channels carried through the datapath (red, green, blue).
    localparam int unsigned N_CH     = 3;
    // Bits of quotient produced by the normaliser, one division cell per bit.
    localparam int unsigned DIV_BITS = 8;
    // Number of fixed reference colours, one distance cell per colour.
    localparam int unsigned N_REF    = 14;
    // Root bits of sqrt(d2 * 2^20); d2 is below 2^18, so the root has 19 bits.
    localparam int unsigned SQ_BITS  = 19;
    localparam int unsigned SQ_W     = 2 * SQ_BITS;
    localparam int unsigned CONF_ONE   = 1024;
    localparam int unsigned CONF_SCALE = 2374;

    typedef struct packed {
        logic [N_CH-1:0][23:0] rem;
        logic [N_CH-1:0][7:0]  quo;
        logic [N_CH-1:0]       sat;
        logic                  zero_clr;
        logic [15:0]           den;
        logic                  shadow;
    } t_pix;

    typedef struct packed {
        logic [N_CH-1:0][7:0] gam;
        logic                 shadow;
        logic [17:0]          best_d2;
        logic [3:0]           best;
    } t_cls;

    typedef struct packed {
        logic [N_CH-1:0][7:0] gam;
        logic                 shadow;
        logic [3:0]           best;
        logic [SQ_W-1:0]      rad;
        logic [SQ_W-1:0]      root;
    } t_rt;

    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,
        8'd6,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,
        8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,
        8'd19,8'd19,
        8'd20,8'd20,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,
        8'd28,8'd29,
        8'd30,8'd30,8'd31,8'd32,8'd33,8'd33,8'd34,8'd35,8'd35,8'd36,8'd37,8'd38,8'd39,8'd39,
        8'd40,8'd41,
        8'd42,8'd43,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd49,8'd50,8'd51,8'd52,8'd53,
        8'd54,8'd55,
        8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd65,8'd66,8'd67,8'd68,8'd69,
        8'd70,8'd71,
        8'd73,8'd74,8'd75,8'd76,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd84,8'd85,8'd87,8'd88,
        8'd89,8'd90,
        8'd91,8'd93,8'd94,8'd95,8'd97,8'd98,8'd99,8'd100,8'd102,8'd103,8'd105,8'd106,8'd107,
        8'd109,8'd110,8'd111,
        8'd113,8'd114,8'd116,8'd117,8'd119,8'd120,8'd121,8'd123,8'd124,8'd126,8'd127,8'd129,
        8'd130,8'd132,8'd133,8'd135,
        8'd137,8'd138,8'd140,8'd141,8'd143,8'd145,8'd146,8'd148,8'd149,8'd151,8'd153,8'd154,
        8'd156,8'd158,8'd159,8'd161,
        8'd163,8'd165,8'd166,8'd168,8'd170,8'd172,8'd173,8'd175,8'd177,8'd179,8'd181,8'd182,
        8'd184,8'd186,8'd188,8'd190,
        8'd192,8'd194,8'd196,8'd197,8'd199,8'd201,8'd203,8'd205,8'd207,8'd209,8'd211,8'd213,
        8'd215,8'd217,8'd219,8'd221,
        8'd223,8'd225,8'd227,8'd229,8'd231,8'd234,8'd236,8'd238,8'd240,8'd242,8'd244,8'd246,
        8'd248,8'd251,8'd253,8'd255
    };

    localparam logic [7:0] REF_RGB [N_REF][N_CH] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255},
        '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
        '{8'd255, 8'd165, 8'd0},   '{8'd127, 8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd127}, '{8'd0,   8'd127, 8'd255},
        '{8'd127, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd127}
    };

endpackage
`default_nettype wire

FILE: hw/rtl/scc_div_cell.sv
`default_nettype none
// One quotient bit of the restoring divider, for all three channels in parallel.
module scc_div_cell #(
    parameter int unsigned BIT = 7
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire scc_pkg::t_pix i_d,
    output scc_pkg::t_pix      o_q
);
    scc_pkg::t_pix n_q;
    scc_pkg::t_pix r_q;
    logic [23:0]   sub;

    always_comb begin
        n_q = i_d;
        sub = {8'd0, i_d.den} << BIT;
        for (int c = 0; c < scc_pkg::N_CH; c++) begin
            if (i_d.rem[c] >= sub) begin
                n_q.rem[c]      = i_d.rem[c] - sub;
                n_q.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

FILE: hw/rtl/scc_ref_cell.sv
`default_nettype none
// Distance to one reference colour; keeps the nearest so far (earlier wins a tie).
module scc_ref_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire scc_pkg::t_cls i_d,
    output scc_pkg::t_cls      o_q
);
    scc_pkg::t_cls     n_q;
    scc_pkg::t_cls     r_q;
    logic signed [8:0] dif [scc_pkg::N_CH];
    logic [15:0]       mag [scc_pkg::N_CH];
    logic [17:0]       d2;

    always_comb begin
        n_q = i_d;
        d2  = '0;
        for (int c = 0; c < scc_pkg::N_CH; c++) begin
            dif[c] = $signed({1'b0, i_d.gam[c]}) - $signed({1'b0, scc_pkg::REF_RGB[IDX][c]});
            // Magnitude of the difference, so that the square fits in 16 bits.
            mag[c] = {8'd0, dif[c][8] ? (~dif[c][7:0] + 8'd1) : dif[c][7:0]};
            d2     = d2 + {2'b00, mag[c] * mag[c]};
        end
        if (IDX == 0 || d2 < i_d.best_d2) begin
            n_q.best_d2 = d2;
            n_q.best    = 4'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

FILE: hw/rtl/scc_sqrt_cell.sv
`default_nettype none
// One step of the digit-by-digit integer square root.
module scc_sqrt_cell #(
    parameter int unsigned STEP = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire scc_pkg::t_rt i_d,
    output scc_pkg::t_rt      o_q
);
    localparam int unsigned W = scc_pkg::SQ_W;
    localparam logic [W-1:0] B = W'(1) << (2 * (scc_pkg::SQ_BITS - 1 - STEP));

    scc_pkg::t_rt n_q;
    scc_pkg::t_rt r_q;
    logic [W:0]   trial;

    always_comb begin
        n_q   = i_d;
        trial = {1'b0, i_d.root} + {1'b0, B};
        if ({1'b0, i_d.rad} >= trial) begin
            n_q.rad  = i_d.rad - trial[W-1:0];
            n_q.root = (i_d.root >> 1) + B;
        end else begin
            n_q.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

FILE: hw/rtl/sensor_color_classifier_top.sv
`default_nettype none
// Channel   Direction  Transfer contents
// s_axis    in         tdata: red, green, blue, clear counts; tuser: shadow_ok
// m_axis    out        tdata: gamma r/g/b, colour index, confidence
// cfg       in         write enable and one bit of invert_gamma
//
// One item per cycle is accepted while the output is not stalled; each result is
// registered in every stage below in turn before it is presented.
// The pipeline is a row of cells: an input stage, eight divider cells, a gamma
// stage, fourteen reference-colour cells, nineteen square-root cells, a
// multiplier stage and the output register. Each stage advances when its
// successor is empty or advancing, so bubbles close up under a stalled output.
// Reset (synchronous, active low) empties every stage and clears invert_gamma.
module sensor_color_classifier_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [15:0] red_count, [31:16] green_count, [47:32] blue_count, [63:48] clear_count
    input  wire logic [63:0] i_s_axis_tdata,
    // [0] shadow_ok
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] gamma_red, [15:8] gamma_green, [23:16] gamma_blue,
    // [27:24] color_index, [38:28] match_confidence, [39] zero
    output logic [39:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata
);
    localparam int unsigned S_DIV  = 1;
    localparam int unsigned S_GAM  = S_DIV + scc_pkg::DIV_BITS;
    localparam int unsigned S_REF  = S_GAM + 1;
    localparam int unsigned S_SQ   = S_REF + scc_pkg::N_REF;
    localparam int unsigned S_MUL  = S_SQ + scc_pkg::SQ_BITS;
    localparam int unsigned S_OUT  = S_MUL + 1;
    localparam int unsigned N_STG  = S_OUT + 1;

    logic             r_invert;
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] rdy;

    // Ready runs backwards: a stage may load if it is empty or its content moves on.
    assign rdy[N_STG-1] = !r_vld[N_STG-1] || i_m_axis_tready;
    for (genvar k = 0; k < N_STG - 1; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_invert <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = rdy[0];

    // Input stage: set up the dividend raw*255 and the special-case flags.
    scc_pkg::t_pix n_in;
    scc_pkg::t_pix r_in;
    logic [15:0]   raw [scc_pkg::N_CH];

    always_comb begin
        n_in          = '0;
        n_in.den      = i_s_axis_tdata[63:48];
        n_in.zero_clr = (i_s_axis_tdata[63:48] == 16'd0);
        n_in.shadow   = i_s_axis_tuser;
        for (int c = 0; c < scc_pkg::N_CH; c++) begin
            raw[c]         = i_s_axis_tdata[16*c +: 16];
            n_in.rem[c]    = {8'd0, raw[c]} * 24'd255;
            // A quotient of 256 or more saturates at 255.
            n_in.sat[c]    = n_in.rem[c] >= {i_s_axis_tdata[63:48], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_in <= n_in;
        end
    end

    // Divider cells, most significant quotient bit first.
    scc_pkg::t_pix div_q [scc_pkg::DIV_BITS+1];
    assign div_q[0] = r_in;
    for (genvar i = 0; i < scc_pkg::DIV_BITS; i++) begin : g_div
        scc_div_cell #(.BIT(scc_pkg::DIV_BITS - 1 - i)) u_div (
            .i_clk (i_clk),
            .i_en  (rdy[S_DIV+i]),
            .i_d   (div_q[i]),
            .o_q   (div_q[i+1])
        );
    end

    // Gamma stage: resolve special cases, look up the curve, optionally invert.
    scc_pkg::t_cls n_gam;
    scc_pkg::t_cls r_gam;
    logic [7:0]    norm [scc_pkg::N_CH];
    logic [7:0]    curve [scc_pkg::N_CH];

    always_comb begin
        n_gam        = '0;
        n_gam.shadow = div_q[scc_pkg::DIV_BITS].shadow;
        for (int c = 0; c < scc_pkg::N_CH; c++) begin
            if (div_q[scc_pkg::DIV_BITS].zero_clr) begin
                norm[c] = 8'd0;
            end else if (div_q[scc_pkg::DIV_BITS].sat[c]) begin
                norm[c] = 8'd255;
            end else begin
                norm[c] = div_q[scc_pkg::DIV_BITS].quo[c];
            end
            curve[c]     = scc_pkg::GAMMA_ROM[norm[c]];
            n_gam.gam[c] = r_invert ? 8'd255 - curve[c] : curve[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_GAM]) begin
            r_gam <= n_gam;
        end
    end

    // Reference-colour cells, colour 0 first so that the lower index wins a tie.
    scc_pkg::t_cls ref_q [scc_pkg::N_REF+1];
    assign ref_q[0] = r_gam;
    for (genvar i = 0; i < scc_pkg::N_REF; i++) begin : g_ref
        scc_ref_cell #(.IDX(i)) u_ref (
            .i_clk (i_clk),
            .i_en  (rdy[S_REF+i]),
            .i_d   (ref_q[i]),
            .o_q   (ref_q[i+1])
        );
    end

    // Square root of d2 * 2^20, one root bit per cell.
    scc_pkg::t_rt n_sq;
    scc_pkg::t_rt sq_q [scc_pkg::SQ_BITS+1];
    always_comb begin
        n_sq        = '0;
        n_sq.gam    = ref_q[scc_pkg::N_REF].gam;
        n_sq.shadow = ref_q[scc_pkg::N_REF].shadow;
        n_sq.best   = ref_q[scc_pkg::N_REF].best;
        n_sq.rad    = {ref_q[scc_pkg::N_REF].best_d2, 20'd0};
    end
    assign sq_q[0] = n_sq;
    for (genvar i = 0; i < scc_pkg::SQ_BITS; i++) begin : g_sq
        scc_sqrt_cell #(.STEP(i)) u_sq (
            .i_clk (i_clk),
            .i_en  (rdy[S_SQ+i]),
            .i_d   (sq_q[i]),
            .o_q   (sq_q[i+1])
        );
    end

    // Multiplier stage: drop = floor(root * 2374 / 2^20).
    logic [30:0] prod;
    logic [10:0] r_drop;
    logic [23:0] r_mul_gam;
    logic [3:0]  r_mul_idx;
    logic        r_mul_sh;

    assign prod = {12'd0, sq_q[scc_pkg::SQ_BITS].root[scc_pkg::SQ_BITS-1:0]}
                  * 31'(scc_pkg::CONF_SCALE);

    always_ff @(posedge i_clk) begin
        if (rdy[S_MUL]) begin
            r_drop    <= prod[30:20];
            r_mul_gam <= sq_q[scc_pkg::SQ_BITS].gam;
            r_mul_idx <= sq_q[scc_pkg::SQ_BITS].best;
            r_mul_sh  <= sq_q[scc_pkg::SQ_BITS].shadow;
        end
    end

    // Output register: confidence with clamp and shadow override.
    logic [10:0] n_conf;
    logic [39:0] r_out;

    always_comb begin
        if (!r_mul_sh || r_drop >= 11'(scc_pkg::CONF_ONE)) begin
            n_conf = 11'd0;
        end else begin
            n_conf = 11'(scc_pkg::CONF_ONE) - r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_OUT]) begin
            r_out <= {1'b0, n_conf, r_mul_idx, r_mul_gam};
        end
    end

    assign o_m_axis_tvalid = r_vld[N_STG-1];
    assign o_m_axis_tdata  = r_out;
endmodule
`default_nettype wire

FILE: hw/rtl/scc_checker.sv
`default_nettype none
module scc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[38:28] <= 11'd1024)
        else $error("confidence above one");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[27:24] <= 4'd13 && !o_m_axis_tdata[39])
        else $error("colour index out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind sensor_color_classifier_top scc_checker u_scc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
